// File: hdl/tbi_pkg.sv
// ----------------------------------------------------------------------------
// tbi_pkg: shared types and constants of the table bilinear interpolator
// Holds mode codes, register indexes, widths and the queue entry type.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;
    localparam int CFG_W        = 5;
    localparam int CFG_RESET    = 16;
    localparam int VAL_W        = 16;
    localparam int IDX_W        = 8;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic REG_ROWS_USED = 1'b0;
    localparam logic REG_COLS_USED = 1'b1;

    // one classified item as it crosses from front to back
    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        row;      // already snapped
        logic [IDX_W-1:0]        col;      // already snapped
        logic signed [VAL_W-1:0] wval;
        logic signed [VAL_W-1:0] rkey;
        logic signed [VAL_W-1:0] ckey;
    } tbi_item_t;

endpackage

// File: hdl/tbi_ram.sv
// ----------------------------------------------------------------------------
// tbi_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tbi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hdl/tbi_front.sv
// ----------------------------------------------------------------------------
// tbi_front: item intake and two-entry queue
// Snaps cell indexes to the table in use and queues items for the engine.
// ----------------------------------------------------------------------------
module tbi_front
    import tbi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       mode,
    input  logic [IDX_W-1:0] row_index,
    input  logic [IDX_W-1:0] col_index,
    input  logic [VAL_W-1:0] write_value,
    input  logic [VAL_W-1:0] row_key,
    input  logic [VAL_W-1:0] col_key,
    input  logic [CFG_W-1:0] rows_used,
    input  logic [CFG_W-1:0] cols_used,
    output logic             q_valid,
    output tbi_item_t        q_item,
    input  logic             q_pop
);

    tbi_item_t   slot_reg [2];
    logic        rd_ptr_reg, wr_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        push;
    tbi_item_t   item_in;
    logic [IDX_W-1:0] last_row, last_col;

    assign busy     = (count_reg == 2'd2);
    assign push     = start && !busy;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign last_row = IDX_W'(rows_used - 5'd1);
    assign last_col = IDX_W'(cols_used - 5'd1);

    always_comb
    begin
        item_in.mode = mode;
        item_in.row  = (row_index > last_row) ? last_row : row_index;
        item_in.col  = (col_index > last_col) ? last_col : col_index;
        item_in.wval = write_value;
        item_in.rkey = row_key;
        item_in.ckey = col_key;
        count_next   = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !q_pop) |=> count_reg == 2'd2)
        else $error("full queue lost an item");

endmodule

// File: hdl/tbi_div.sv
// ----------------------------------------------------------------------------
// tbi_div: sequential signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tbi_div
    import tbi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [33:0] num,
    input  logic signed [17:0] den,
    output logic               done,
    output logic signed [33:0] quo
);

    localparam int NW = 34;

    logic [NW-1:0] rem_reg, q_reg;
    logic [17:0]   dv_reg;
    logic          neg_reg, run_reg;
    logic [5:0]    cnt_reg;
    logic [NW:0]   trial;
    logic [NW-1:0] nabs;

    assign nabs  = num[NW-1] ? NW'(-num) : NW'(num);
    assign trial = {rem_reg, q_reg[NW-1]} - {17'd0, dv_reg};
    assign done  = run_reg && (cnt_reg == 6'd0);
    assign quo   = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 6'(NW);
        end
        else if (run_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            q_reg   <= nabs;
            dv_reg  <= den[17] ? 18'(-den) : 18'(den);
            neg_reg <= num[NW-1] ^ den[17];
        end
        else if (run_reg && cnt_reg != 6'd0)
        begin
            // shift in next numerator bit, keep the difference if it fits
            if (!trial[NW])
            begin
                rem_reg <= trial[NW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[NW-2:0], q_reg[NW-1]};
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

endmodule

// File: hdl/tbi_back.sv
// ----------------------------------------------------------------------------
// tbi_back: table engine
// Executes write, read and lookup items against the table RAM; others give zero.
// ----------------------------------------------------------------------------
module tbi_back
    import tbi_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  tbi_item_t               q_item,
    output logic                    q_pop,
    input  logic [CFG_W-1:0]        rows_used,
    input  logic [CFG_W-1:0]        cols_used,
    output logic                    done,
    output logic signed [VAL_W-1:0] result_value
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // read one cell
    localparam logic [3:0] S_LBL   = 4'd2;  // label fetch
    localparam logic [3:0] S_LCHK  = 4'd3;  // label compare
    localparam logic [3:0] S_CELL  = 4'd4;  // cell fetch for interp
    localparam logic [3:0] S_CGET  = 4'd5;
    localparam logic [3:0] S_IGO   = 4'd6;
    localparam logic [3:0] S_IWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]  state_reg, state_next;
    tbi_item_t   it_reg;
    // phase: 0 row end, 1 row first, 2 row scan, 3..5 same for columns
    logic [2:0]  ph_reg;
    logic [CFG_W-1:0] i_reg;
    logic [CFG_W-1:0] rl_reg, rh_reg, cl_reg, ch_reg;
    logic [2:0]  ci_reg;                     // which cell is being fetched
    logic signed [VAL_W-1:0] cv_reg [7];     // ra rb c1 d1 c2 d2 ca; cb in cb_reg
    logic signed [VAL_W-1:0] cb_reg;
    logic signed [VAL_W-1:0] m_reg [2];
    logic [1:0]  k_reg;                      // interpolation number
    logic signed [VAL_W-1:0] res_reg;
    logic        done_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [VAL_W-1:0]   ram_wd, ram_rd;
    logic signed [VAL_W-1:0] rdv;
    logic [CFG_W-1:0]   fr, fc;
    logic [IDX_W+CFG_W-1:0] lin;

    logic               dgo, ddone;
    logic signed [33:0] dnum, dquo;
    logic signed [17:0] dden;
    logic signed [VAL_W-1:0] ix, ia, ib, ic, id;
    logic signed [17:0] dx, dd;
    logic signed [34:0] tsum;
    logic signed [VAL_W-1:0] isat;
    logic               key_row;
    logic signed [VAL_W-1:0] key;
    logic [CFG_W-1:0]   nlast;

    assign rdv = $signed(ram_rd);

    tbi_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wd),
        .rdata (ram_rd)
    );

    tbi_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (dgo),
        .num  (dnum),
        .den  (dden),
        .done (ddone),
        .quo  (dquo)
    );

    assign key_row = (ph_reg < 3'd3);
    assign key     = key_row ? it_reg.rkey : it_reg.ckey;
    assign nlast   = (key_row ? rows_used : cols_used) - 5'd1;

    // cell coordinates of the current fetch
    always_comb
    begin
        fr = '0;
        fc = '0;
        if (state_reg == S_LBL)
        begin
            if (ph_reg == 3'd0 || ph_reg == 3'd3)
            begin
                fr = key_row ? nlast : 5'd0;
                fc = key_row ? 5'd0 : nlast;
            end
            else if (ph_reg == 3'd1 || ph_reg == 3'd4)
            begin
                fr = key_row ? 5'd1 : 5'd0;
                fc = key_row ? 5'd0 : 5'd1;
            end
            else
            begin
                fr = key_row ? i_reg : 5'd0;
                fc = key_row ? 5'd0 : i_reg;
            end
        end
        else
        begin
            case (ci_reg)
                3'd0:    begin fr = rl_reg; fc = 5'd0;   end
                3'd1:    begin fr = rh_reg; fc = 5'd0;   end
                3'd2:    begin fr = rl_reg; fc = cl_reg; end
                3'd3:    begin fr = rh_reg; fc = cl_reg; end
                3'd4:    begin fr = rl_reg; fc = ch_reg; end
                3'd5:    begin fr = rh_reg; fc = ch_reg; end
                3'd6:    begin fr = 5'd0;   fc = cl_reg; end
                default: begin fr = 5'd0;   fc = ch_reg; end
            endcase
        end
        if (state_reg == S_IDLE)
        begin
            lin = (IDX_W+CFG_W)'(q_item.row * cols_used + q_item.col);
        end
        else
        begin
            lin = (IDX_W+CFG_W)'(fr * cols_used + fc);
        end
    end

    assign ram_addr = AW'(lin);
    assign ram_we   = (state_reg == S_IDLE) && q_valid && q_item.mode == MODE_WRITE;
    assign ram_wd   = q_item.wval;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // interpolation operands
    always_comb
    begin
        if (k_reg == 2'd2)
        begin
            ix = it_reg.ckey; ia = cv_reg[6]; ib = cb_reg; ic = m_reg[0]; id = m_reg[1];
        end
        else
        begin
            ix = it_reg.rkey; ia = cv_reg[0]; ib = cv_reg[1];
            ic = k_reg[0] ? cv_reg[4] : cv_reg[2];
            id = k_reg[0] ? cv_reg[5] : cv_reg[3];
        end
        dx   = 18'(ix) - 18'(ia);
        dd   = 18'(id) - 18'(ic);
        dden = 18'(ib) - 18'(ia);
        dnum = 34'(dx * dd);
        dgo  = (state_reg == S_IGO) && (ia != ib);
        tsum = 35'(dquo) + 35'(ic);
        if (tsum > 35'sd32767)
        begin
            isat = 16'sh7FFF;
        end
        else if (tsum < -35'sd32768)
        begin
            isat = -16'sh8000;
        end
        else
        begin
            isat = VAL_W'(tsum);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (q_valid)
                     begin
                         if (q_item.mode == MODE_READ) state_next = S_RD;
                         else if (q_item.mode == MODE_LOOKUP) state_next = S_LBL;
                         else state_next = S_OUT;
                     end
            S_RD:    state_next = S_OUT;
            S_LBL:   state_next = S_LCHK;
            S_LCHK:
            begin
                // end of a row or column search
                if (((ph_reg == 3'd0 || ph_reg == 3'd3) && key >= rdv) ||
                    ((ph_reg == 3'd1 || ph_reg == 3'd4) && key <= rdv) ||
                    ((ph_reg == 3'd2 || ph_reg == 3'd5) &&
                     (rdv >= key || i_reg >= nlast)))
                    state_next = key_row ? S_LBL : S_CELL;
                else
                    state_next = S_LBL;
            end
            S_CELL:  state_next = S_CGET;
            S_CGET:  state_next = (ci_reg == 3'd7) ? S_IGO : S_CELL;
            S_IGO:
            begin
                if (ia == ib) state_next = (k_reg == 2'd2) ? S_OUT : S_IGO;
                else state_next = S_IWAIT;
            end
            S_IWAIT:
            begin
                if (ddone) state_next = (k_reg == 2'd2) ? S_OUT : S_IGO;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                it_reg <= q_item;
                res_reg <= (q_item.mode == MODE_WRITE) ? q_item.wval : '0;
                ph_reg <= 3'd0;
                ci_reg <= 3'd0;
                k_reg  <= 2'd0;
                rl_reg <= '0; rh_reg <= '0; cl_reg <= '0; ch_reg <= '0;
            end
            S_RD:
            begin
                res_reg <= rdv;
            end
            S_LCHK:
            begin
                if (ph_reg == 3'd0 || ph_reg == 3'd3)
                begin
                    if (key >= rdv)
                    begin
                        if (key_row) begin rl_reg <= nlast; rh_reg <= nlast; end
                        else begin cl_reg <= nlast; ch_reg <= nlast; end
                        ph_reg <= 3'd3;
                    end
                    else ph_reg <= ph_reg + 3'd1;
                end
                else if (ph_reg == 3'd1 || ph_reg == 3'd4)
                begin
                    if (key <= rdv)
                    begin
                        if (key_row) begin rl_reg <= 5'd1; rh_reg <= 5'd1; end
                        else begin cl_reg <= 5'd1; ch_reg <= 5'd1; end
                        ph_reg <= 3'd3;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                    i_reg <= 5'd1;
                end
                else
                begin
                    // scan: first label at or above the key
                    if (rdv >= key)
                    begin
                        if (key_row)
                        begin
                            rl_reg <= (rdv == key) ? i_reg : i_reg - 5'd1;
                            rh_reg <= i_reg;
                        end
                        else
                        begin
                            cl_reg <= (rdv == key) ? i_reg : i_reg - 5'd1;
                            ch_reg <= i_reg;
                        end
                        ph_reg <= 3'd3;
                    end
                    else if (i_reg >= nlast)
                    begin
                        ph_reg <= 3'd3;
                    end
                    i_reg <= i_reg + 5'd1;
                end
            end
            S_CGET:
            begin
                if (ci_reg == 3'd7) cb_reg <= rdv;
                else cv_reg[ci_reg] <= rdv;
                ci_reg <= ci_reg + 3'd1;
            end
            S_IGO:
            begin
                if (ia == ib)
                begin
                    if (k_reg == 2'd2) res_reg <= ic;
                    else m_reg[k_reg[0]] <= ic;
                    k_reg <= k_reg + 2'd1;
                end
            end
            S_IWAIT:
            begin
                if (ddone)
                begin
                    if (k_reg == 2'd2) res_reg <= isat;
                    else m_reg[k_reg[0]] <= isat;
                    k_reg <= k_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign done         = done_reg;
    assign result_value = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_OUT)
        else $error("result without finishing an item");
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("table write outside intake");
    assert property (@(posedge clk) disable iff (!rst_n)
        dgo |-> state_reg == S_IGO)
        else $error("divider started out of sequence");

endmodule

// File: hdl/table_bilinear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// table_bilinear_interpolator_unit: 2D calibration table with lookup
// Write, read and bilinear lookup over a label-indexed table in RAM.
// ----------------------------------------------------------------------------
// Throughput: one item at a time in the engine; a two-item queue takes items
// while it works, and busy rises when the queue is full. The serial divider
// (one bit per cycle) and the single RAM port set the lookup length.
// Reset clears control and sets both size registers to 16, capped at their
// maximum; the table contents are undefined until written. done cannot be stalled.
module table_bilinear_interpolator_unit
    import tbi_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              mode,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] write_value,
    input  logic signed [VAL_W-1:0] row_key,
    input  logic signed [VAL_W-1:0] col_key,
    output logic                    done,
    output logic signed [VAL_W-1:0] result_value,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam logic [CFG_W-1:0] ROWS_RESET =
        CFG_W'((MAX_ROWS < CFG_RESET) ? MAX_ROWS : CFG_RESET);
    localparam logic [CFG_W-1:0] COLS_RESET =
        CFG_W'((MAX_COLS < CFG_RESET) ? MAX_COLS : CFG_RESET);

    logic [CFG_W-1:0] rows_reg, cols_reg, sat_r, sat_c;
    logic             q_valid, q_pop;
    tbi_item_t        q_item;

    always_comb
    begin
        sat_r = (cfg_data < 5'd2) ? 5'd2 :
                (32'(cfg_data) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : cfg_data;
        sat_c = (cfg_data < 5'd2) ? 5'd2 :
                (32'(cfg_data) > MAX_COLS) ? CFG_W'(MAX_COLS) : cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ROWS_USED) rows_reg <= sat_r;
            else cols_reg <= sat_c;
        end
    end

    tbi_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .row_index(row_index), .col_index(col_index),
        .write_value(write_value), .row_key(row_key), .col_key(col_key),
        .rows_used(rows_reg), .cols_used(cols_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    tbi_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .rows_used(rows_reg), .cols_used(cols_reg),
        .done(done), .result_value(result_value)
    );

endmodule

// File: tb/tb_table_bilinear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// tb_table_bilinear_interpolator_unit: self-checking bench for the table unit
// Builds label tables, then drives writes, reads and lookups against an
// internal predictor of the table and its interpolation, checking each done.
// ----------------------------------------------------------------------------
module tb_table_bilinear_interpolator_unit;
    import tbi_pkg::*;

    localparam int NR = DEF_MAX_ROWS;
    localparam int NC = DEF_MAX_COLS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              mode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] write_value;
    logic signed [VAL_W-1:0] row_key;
    logic signed [VAL_W-1:0] col_key;
    logic                    done;
    logic signed [VAL_W-1:0] result_value;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    logic signed [VAL_W-1:0] table_copy [NR*NC];
    int unsigned             rows_now;
    int unsigned             cols_now;
    logic signed [VAL_W-1:0] expected_values [$];
    int                      error_count;
    int                      idle_cycles;

    table_bilinear_interpolator_unit #(.MAX_ROWS(NR), .MAX_COLS(NC)) uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
        if (r > rows_now - 1) r = rows_now - 1;
        if (c > cols_now - 1) c = cols_now - 1;
        return r * cols_now + c;
    endfunction

    function automatic int cell_at(int unsigned r, int unsigned c);
        return table_copy[cell_addr(r, c)];
    endfunction

    function automatic int label_at(bit along_rows, int unsigned i);
        return along_rows ? cell_at(i, 0) : cell_at(0, i);
    endfunction

    task automatic find_bracket(input bit along_rows, input int key,
                                output int unsigned lo, output int unsigned hi);
        int unsigned n;
        int v;
        n = along_rows ? rows_now : cols_now;
        lo = 0;
        hi = 0;
        if (key >= label_at(along_rows, n - 1))
        begin
            lo = n - 1;
            hi = n - 1;
            return;
        end
        if (key <= label_at(along_rows, 1))
        begin
            lo = 1;
            hi = 1;
            return;
        end
        for (int unsigned i = 1; i < n; i++)
        begin
            v = label_at(along_rows, i);
            if (v == key)
            begin
                lo = i;
                hi = i;
                return;
            end
            if (v > key)
            begin
                lo = i - 1;
                hi = i;
                return;
            end
        end
    endtask

    function automatic int lerp_sat(int x, int a, int b, int c, int d);
        longint t;
        if (a == b) return c;
        // SV division truncates toward zero, as required
        t = (longint'(x) - a) * (longint'(d) - c) / (longint'(b) - a) + c;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return int'(t);
    endfunction

    task automatic predict_item(input logic [1:0] m, input int unsigned ri,
                                input int unsigned ci, input logic signed [15:0] wv,
                                input logic signed [15:0] rk, input logic signed [15:0] ck);
        int unsigned rl, rh, cl, ch;
        int ra, rb, m1, m2, res;
        res = 0;
        if (m == MODE_WRITE)
        begin
            table_copy[cell_addr(ri, ci)] = wv;
            res = wv;
        end
        else if (m == MODE_READ)
            res = cell_at(ri, ci);
        else if (m == MODE_LOOKUP)
        begin
            find_bracket(1'b1, rk, rl, rh);
            find_bracket(1'b0, ck, cl, ch);
            ra = cell_at(rl, 0);
            rb = cell_at(rh, 0);
            m1 = lerp_sat(rk, ra, rb, cell_at(rl, cl), cell_at(rh, cl));
            m2 = lerp_sat(rk, ra, rb, cell_at(rl, ch), cell_at(rh, ch));
            res = lerp_sat(ck, cell_at(0, cl), cell_at(0, ch), m1, m2);
        end
        expected_values.push_back(res[15:0]);
    endtask

    // drop start only when a real gap follows
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [1:0] m, input int unsigned ri,
                             input int unsigned ci, input logic signed [15:0] wv,
                             input logic signed [15:0] rk, input logic signed [15:0] ck);
        start       <= 1'b1;
        mode        <= m;
        row_index   <= ri[7:0];
        col_index   <= ci[7:0];
        write_value <= wv;
        row_key     <= rk;
        col_key     <= ck;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_item(m, ri, ci, wv, rk, ck);
        random_gap();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_values.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        int unsigned v;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        v = val & 5'h1f;
        if (v < 2) v = 2;
        if (idx == REG_ROWS_USED) rows_now = (v > NR) ? NR : v;
        else cols_now = (v > NC) ? NC : v;
        @(posedge clk);
    endtask

    // fill used cells: labels step upward (may wrap at 16 bits), random body
    task automatic load_table(input bit flat_labels);
        int step;
        int base;
        base = $urandom_range(0, 2000) - 1000;
        send_item(MODE_WRITE, 0, 0, 16'($urandom), 0, 0);
        for (int unsigned c = 1; c < cols_now; c++)
        begin
            step = flat_labels && c == 2 ? 0 : $urandom_range(1, 4000);
            base = base + step;
            send_item(MODE_WRITE, 0, c, base[15:0], 0, 0);
        end
        base = $urandom_range(0, 2000) - 1000;
        for (int unsigned r = 1; r < rows_now; r++)
        begin
            step = flat_labels && r == 2 ? 0 : $urandom_range(1, 4000);
            base = base + step;
            send_item(MODE_WRITE, r, 0, base[15:0], 0, 0);
            for (int unsigned c = 1; c < cols_now; c++)
                send_item(MODE_WRITE, r, c, 16'($urandom), 0, 0);
        end
    endtask

    function automatic logic [15:0] pick_key(bit along_rows);
        int unsigned n;
        int lo, hi;
        n = along_rows ? rows_now : cols_now;
        lo = label_at(along_rows, 1);
        hi = label_at(along_rows, n - 1);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'(label_at(along_rows, $urandom_range(1, n - 1)));
            2: return 16'(lo - $urandom_range(0, 50));
            3: return 16'(hi + $urandom_range(0, 50));
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic test_directed();
        load_table(1'b0);
        send_item(MODE_READ, 255, 255, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0);
        send_item(MODE_LOOKUP, 0, 0, 0, 16'sh7fff, 16'sh7fff);
        send_item(MODE_LOOKUP, 0, 0, 0, 16'sh8000, 16'sh8000);
        send_item(MODE_LOOKUP, 0, 0, 0, 16'sh8000, 16'sh7fff);
        send_item(MODE_LOOKUP, 0, 0, 0, 16'($urandom), 16'($urandom));
        send_item(MODE_UNUSED, 3, 3, 16'hffff, 0, 0);
        send_item(MODE_WRITE, 255, 255, 16'sh7fff, 0, 0);
        send_item(MODE_WRITE, 255, 255, 16'sh8000, 0, 0);
        send_item(MODE_READ, 255, 255, 0, 0, 0);
    endtask

    task automatic test_random_phase(input int unsigned nr, input int unsigned nc,
                                     input bit flat_labels, input int count);
        logic [1:0] m;
        wait_drained();
        write_reg(REG_ROWS_USED, nr);
        write_reg(REG_COLS_USED, nc);
        load_table(flat_labels);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: m = MODE_WRITE;
                1, 2: m = MODE_READ;
                3: m = MODE_UNUSED;
                default: m = MODE_LOOKUP;
            endcase
            // body writes keep labels ascending; label writes only in noise
            if (m == MODE_WRITE && $urandom_range(0, 7) != 0)
                send_item(m, $urandom_range(1, 255), $urandom_range(1, 255),
                          16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_item(m, $urandom_range(0, 255), $urandom_range(0, 255),
                          16'($urandom), pick_key(1'b1), pick_key(1'b0));
            if (i == count / 2) wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (expected_values.size() == 0)
            begin
                $error("result_value: expected none, actual %0d", result_value);
                error_count++;
            end
            else if (result_value !== expected_values[0])
            begin
                $error("result_value: expected %0d, actual %0d",
                       expected_values[0], result_value);
                error_count++;
                void'(expected_values.pop_front());
            end
            else
                void'(expected_values.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rows_now    = NR;
        cols_now    = NC;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        mode        <= MODE_WRITE;
        row_index   <= '0;
        col_index   <= '0;
        write_value <= '0;
        row_key     <= '0;
        col_key     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_ROWS_USED;
        cfg_data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(2, 2, 1'b0, 150);
        test_random_phase(0, 31, 1'b0, 100);
        test_random_phase(5, 7, 1'b1, 150);
        test_random_phase(16, 16, 1'b0, 200);
        test_random_phase(3, 12, 1'b0, 150);
        test_random_phase(9, 4, 1'b1, 150);
        wait_drained();
        if (error_count == 0 && expected_values.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: filelist.f
hdl/tbi_pkg.sv
hdl/tbi_ram.sv
hdl/tbi_front.sv
hdl/tbi_div.sv
hdl/tbi_back.sv
hdl/table_bilinear_interpolator_unit.sv
tb/tb_table_bilinear_interpolator_unit.sv
